>>> design/wpdd_pkg.sv
package wpdd_pkg;

	localparam int MEAN_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int FIELD_W        = 32;
	localparam int QUO_BITS       = 31;
	localparam int MAG_W          = 34;
	localparam int PROD_W         = 49;
	localparam int NORM_SHIFT     = 16;
	localparam logic [15:0] INV_SQRT2_Q16 = 16'd46341;
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_CHECK,
		DIV_RUN,
		DIV_DONE
	} wpdd_div_state_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD_A,
		ST_WAIT_A,
		ST_LOAD_B,
		ST_WAIT_B,
		ST_DIFF,
		ST_NORM,
		ST_ROUND,
		ST_FINISH
	} wpdd_state_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} wpdd_div_sts_t;

	function automatic logic signed [FIELD_W-1:0] sat_quo(
		input logic neg,
		input logic ovf,
		input logic [QUO_BITS-1:0] quo
	);
		logic [FIELD_W-1:0] ext;
		ext = {1'b0, quo};
		if (ovf) begin
			sat_quo = neg ? {1'b1, {(FIELD_W-1){1'b0}}} : {1'b0, {(FIELD_W-1){1'b1}}};
		end else begin
			sat_quo = neg ? -ext : ext;
		end
	endfunction

	function automatic logic signed [FIELD_W-1:0] sat_mag(
		input logic neg,
		input logic [MAG_W-1:0] mag
	);
		logic big;
		big = (mag[MAG_W-1:FIELD_W-1] != '0);
		if (neg) begin
			sat_mag = big ? {1'b1, {(FIELD_W-1){1'b0}}} : -mag[FIELD_W-1:0];
		end else begin
			sat_mag = big ? {1'b0, {(FIELD_W-1){1'b1}}} : mag[FIELD_W-1:0];
		end
	endfunction

endpackage

>>> design/wpdd_if.sv
interface wpdd_window_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [wpdd_pkg::FIELD_W-1:0] mean_a;
	logic signed [wpdd_pkg::FIELD_W-1:0] mean_b;
	logic                                  first_window;

	modport source(output valid, mean_a, mean_b, first_window, input ready);
	modport sink(input valid, mean_a, mean_b, first_window, output ready);
endinterface

interface wpdd_result_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [wpdd_pkg::FIELD_W-1:0] rdf_a;
	logic signed [wpdd_pkg::FIELD_W-1:0] rdf_b;
	logic signed [wpdd_pkg::FIELD_W-1:0] ddf;
	logic                                  zero_denominator;

	modport source(output valid, rdf_a, rdf_b, ddf, zero_denominator, input ready);
	modport sink(input valid, rdf_a, rdf_b, ddf, zero_denominator, output ready);
endinterface

>>> design/wpdd_div.sv
module wpdd_div #(
	parameter int MEAN_WIDTH = wpdd_pkg::MEAN_WIDTH_DEF,
	parameter int FRAC_BITS  = wpdd_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [MEAN_WIDTH:0]             num,
	input  logic [MEAN_WIDTH:0]             den,
	output logic [wpdd_pkg::QUO_BITS-1:0]   quo,
	output wpdd_pkg::wpdd_div_sts_t         sts
);
	import wpdd_pkg::*;

	localparam int DW = MEAN_WIDTH + 1;
	localparam int NW = DW + QUO_BITS;
	localparam int CW = $clog2(QUO_BITS);

	wpdd_div_state_t state_q, state_d;
	logic [DW-1:0]       den_q;
	logic [DW-1:0]       rem_q;
	logic [QUO_BITS-1:0] nlo_q;
	logic [QUO_BITS-1:0] quo_q;
	logic                ovf_q;
	logic [CW-1:0]       cnt_q;

	logic [NW-1:0] wide;
	logic [DW:0]   trial;
	logic [DW+1:0] diff;
	logic          geq;

	// The dividend is the numerator magnitude with the fraction bits appended.
	assign wide  = NW'(num) << FRAC_BITS;
	assign trial = (state_q == DIV_CHECK) ? {1'b0, rem_q} : {rem_q, nlo_q[QUO_BITS-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign geq   = !diff[DW+1];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DIV_IDLE: begin
				if (start) state_d = DIV_CHECK;
			end
			DIV_CHECK: begin
				state_d = geq ? DIV_DONE : DIV_RUN;
			end
			DIV_RUN: begin
				if (cnt_q == '0) state_d = DIV_DONE;
			end
			DIV_DONE: begin
				state_d = DIV_IDLE;
			end
			default: begin
				state_d = DIV_IDLE;
			end
		endcase
	end

	always_comb begin
		sts.done = (state_q == DIV_DONE);
		sts.ovf  = ovf_q;
		quo      = quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			DIV_IDLE: begin
				if (start) begin
					den_q <= den;
					rem_q <= wide[NW-1:QUO_BITS];
					nlo_q <= wide[QUO_BITS-1:0];
					quo_q <= '0;
					cnt_q <= CW'(QUO_BITS - 1);
				end
			end
			DIV_CHECK: begin
				ovf_q <= geq;
			end
			DIV_RUN: begin
				rem_q <= geq ? diff[DW-1:0] : trial[DW-1:0];
				nlo_q <= {nlo_q[QUO_BITS-2:0], 1'b0};
				quo_q <= {quo_q[QUO_BITS-2:0], geq};
				cnt_q <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> design/window_pair_double_difference.sv
// Relative differences of consecutive integration windows for two channels.
// Items arrive on the window channel (valid/ready) with the means of channel A
// and B and a flag that opens a new run. The first window of a run, and any
// window while no previous one is held, is stored and produces no item on the
// result channel. Every later window produces one result item holding
// (cur - prev) / (cur + prev) for both channels, their difference ddf
// (optionally scaled by 1/sqrt(2) when normalize is set), all saturated, and a
// zero_denominator flag that zeroes the values when either sum is zero.
// An item with a result goes through two passes of the shared restoring
// divider (load, range check, 31 quotient bits at one per cycle, done; the
// quotient bits are skipped when the range check finds overflow), the
// difference step, the multiply and rounding steps when normalizing, and the
// output load. The window channel is ready only while the block is idle, so a
// new window is not taken while an earlier item is still in work. A finished
// result waits in the output register, so a new window is accepted while the
// receiver stalls; its result is held back until the register frees. A
// stored-only window leaves the block idle and ready for the next window in
// the following cycle; a zero denominator result skips the divider and goes
// straight to the output load. Reset clears the held window, the normalize
// register and the output valid. Write normalize only while idle.
module window_pair_double_difference #(
	parameter int MEAN_WIDTH = wpdd_pkg::MEAN_WIDTH_DEF,
	parameter int FRAC_BITS  = wpdd_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	wpdd_window_if.sink   window,
	wpdd_result_if.source result,
	input  logic          cfg_we,
	input  logic          cfg_wdata
);
	import wpdd_pkg::*;

	localparam int DW   = MEAN_WIDTH + 1;
	localparam int RawW = (MEAN_WIDTH < FIELD_W) ? MEAN_WIDTH : FIELD_W;

	wpdd_state_t state_q, state_d;
	logic normalize_q;
	logic have_prev_q;
	logic out_valid_q;

	logic signed [MEAN_WIDTH-1:0] prev_a_q, prev_b_q;
	logic [DW-1:0] num_a_q, den_a_q, num_b_q, den_b_q;
	logic          neg_a_q, neg_b_q;
	logic signed [FIELD_W-1:0] ra_q, rb_q;
	logic [MAG_W-2:0]  mag_q;
	logic              neg_q;
	logic [PROD_W-1:0] prod_q;
	logic              zden_q;

	logic signed [FIELD_W-1:0] rdf_a_q, rdf_b_q, ddf_q;
	logic                      zero_den_q;

	logic [MEAN_WIDTH-1:0]        a_raw, b_raw;
	logic signed [MEAN_WIDTH-1:0] cur_a, cur_b;
	logic signed [DW-1:0]         num_a, den_a, num_b, den_b;
	logic [DW-1:0]                num_a_mag, den_a_mag, num_b_mag, den_b_mag;
	logic                         accept, emit, zero_den;
	logic signed [FIELD_W:0]      dd;

	logic                  div_start;
	logic                  sel_b;
	logic                  out_load;
	logic [DW-1:0]         div_num, div_den;
	logic [QUO_BITS-1:0]   div_quo;
	wpdd_div_sts_t         div_sts;

	assign a_raw = MEAN_WIDTH'(window.mean_a[RawW-1:0]);
	assign b_raw = MEAN_WIDTH'(window.mean_b[RawW-1:0]);
	assign cur_a = signed'(a_raw);
	assign cur_b = signed'(b_raw);

	assign num_a = DW'(cur_a) - DW'(prev_a_q);
	assign den_a = DW'(cur_a) + DW'(prev_a_q);
	assign num_b = DW'(cur_b) - DW'(prev_b_q);
	assign den_b = DW'(cur_b) + DW'(prev_b_q);

	assign num_a_mag = num_a[DW-1] ? -num_a : num_a;
	assign den_a_mag = den_a[DW-1] ? -den_a : den_a;
	assign num_b_mag = num_b[DW-1] ? -num_b : num_b;
	assign den_b_mag = den_b[DW-1] ? -den_b : den_b;

	assign accept   = window.valid && window.ready;
	assign emit     = have_prev_q && !window.first_window;
	assign zero_den = (den_a == '0) || (den_b == '0);

	assign dd = (FIELD_W+1)'(ra_q) - (FIELD_W+1)'(rb_q);

	assign div_num = sel_b ? num_b_q : num_a_q;
	assign div_den = sel_b ? den_b_q : den_a_q;

	wpdd_div #(
		.MEAN_WIDTH (MEAN_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.sts    (div_sts)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && emit) state_d = zero_den ? ST_FINISH : ST_LOAD_A;
			end
			ST_LOAD_A: begin
				state_d = ST_WAIT_A;
			end
			ST_WAIT_A: begin
				if (div_sts.done) state_d = ST_LOAD_B;
			end
			ST_LOAD_B: begin
				state_d = ST_WAIT_B;
			end
			ST_WAIT_B: begin
				if (div_sts.done) state_d = ST_DIFF;
			end
			ST_DIFF: begin
				state_d = normalize_q ? ST_NORM : ST_FINISH;
			end
			ST_NORM: begin
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || result.ready) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		window.ready = (state_q == ST_IDLE);
		div_start    = (state_q == ST_LOAD_A) || (state_q == ST_LOAD_B);
		sel_b        = (state_q == ST_LOAD_B);
		out_load     = (state_q == ST_FINISH) && (!out_valid_q || result.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			normalize_q <= 1'b0;
			have_prev_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) normalize_q <= cfg_wdata;
			if (accept) have_prev_q <= 1'b1;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prev_a_q <= cur_a;
			prev_b_q <= cur_b;
			num_a_q  <= num_a_mag;
			den_a_q  <= den_a_mag;
			num_b_q  <= num_b_mag;
			den_b_q  <= den_b_mag;
			neg_a_q  <= num_a[DW-1] ^ den_a[DW-1];
			neg_b_q  <= num_b[DW-1] ^ den_b[DW-1];
			zden_q   <= zero_den;
			ra_q     <= '0;
			rb_q     <= '0;
			mag_q    <= '0;
			neg_q    <= 1'b0;
		end
		if (state_q == ST_WAIT_A && div_sts.done) ra_q <= sat_quo(neg_a_q, div_sts.ovf, div_quo);
		if (state_q == ST_WAIT_B && div_sts.done) rb_q <= sat_quo(neg_b_q, div_sts.ovf, div_quo);
		if (state_q == ST_DIFF) begin
			neg_q <= dd[FIELD_W];
			mag_q <= dd[FIELD_W] ? -dd : dd;
		end
		if (state_q == ST_NORM) prod_q <= PROD_W'(mag_q) * PROD_W'(INV_SQRT2_Q16);
		if (state_q == ST_ROUND) mag_q <= (MAG_W-1)'((prod_q + ROUND_HALF) >> NORM_SHIFT);
		if (out_load) begin
			rdf_a_q    <= ra_q;
			rdf_b_q    <= rb_q;
			ddf_q      <= sat_mag(neg_q, MAG_W'(mag_q));
			zero_den_q <= zden_q;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.rdf_a            = rdf_a_q;
	assign result.rdf_b            = rdf_b_q;
	assign result.ddf              = ddf_q;
	assign result.zero_denominator = zero_den_q;

	a_zero_den_values: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.zero_denominator) |->
			(result.rdf_a == '0 && result.rdf_b == '0 && result.ddf == '0))
		else $error("zero denominator result carries nonzero values");

	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> (state_q == ST_WAIT_A || state_q == ST_WAIT_B))
		else $error("divider finished outside a wait state");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished item not presented on the result channel");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit && !zero_den) |=> (!window.ready && state_q == ST_LOAD_A))
		else $error("window accepted while a division is pending");

endmodule

>>> tb/sv/wpdd_checker.sv
module wpdd_checker (
	input  logic   clk,
	input  logic   arst_n,
	wpdd_window_if window,
	wpdd_result_if result,
	input  logic   cfg_we,
	input  logic   cfg_wdata,
	output int     mismatches,
	output int     outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import wpdd_pkg::*;

	typedef struct packed {
		logic signed [FIELD_W-1:0] rdf_a;
		logic signed [FIELD_W-1:0] rdf_b;
		logic signed [FIELD_W-1:0] ddf;
		logic                      zero_den;
	} pair_result_t;

	pair_result_t              expected_q[$];
	logic signed [FIELD_W-1:0] held_a;
	logic signed [FIELD_W-1:0] held_b;
	logic                      held_valid;
	logic                      scale_ddf;

	function automatic logic signed [FIELD_W-1:0] clamp_field(input logic neg,
		input logic [63:0] mag);
		if (neg) begin
			if (mag >= 64'h8000_0000) begin
				return {1'b1, {(FIELD_W-1){1'b0}}};
			end
			return -mag[FIELD_W-1:0];
		end
		if (mag > 64'h7FFF_FFFF) begin
			return {1'b0, {(FIELD_W-1){1'b1}}};
		end
		return mag[FIELD_W-1:0];
	endfunction

	function automatic logic [63:0] magnitude(input longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	// Quotient (cur - prv) / (cur + prv) on magnitudes, truncated toward zero.
	function automatic logic signed [FIELD_W-1:0] rel_diff(input longint cur,
		input longint prv);
		longint     num;
		longint     den;
		logic       neg;
		logic [63:0] quo;
		num = cur - prv;
		den = cur + prv;
		neg = (num < 0) != (den < 0);
		quo = (magnitude(num) << FRAC_BITS_DEF) / magnitude(den);
		return clamp_field(neg, quo);
	endfunction

	function automatic pair_result_t predict_pair(input logic signed [FIELD_W-1:0] cur_a,
		input logic signed [FIELD_W-1:0] cur_b);
		pair_result_t res;
		longint       diff;
		logic [63:0]  mag;
		res = '0;
		if (longint'(cur_a) + longint'(held_a) == 0
				|| longint'(cur_b) + longint'(held_b) == 0) begin
			res.zero_den = 1'b1;
		end else begin
			res.rdf_a = rel_diff(longint'(cur_a), longint'(held_a));
			res.rdf_b = rel_diff(longint'(cur_b), longint'(held_b));
			diff = longint'(res.rdf_a) - longint'(res.rdf_b);
			mag = magnitude(diff);
			if (scale_ddf) begin
				mag = (mag * 64'(INV_SQRT2_Q16) + (64'd1 << (NORM_SHIFT - 1))) >> NORM_SHIFT;
			end
			res.ddf = clamp_field(diff < 0, mag);
		end
		return res;
	endfunction

	function automatic void report(input string what, input pair_result_t want,
		input pair_result_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t %s: expected rdf_a=%0d rdf_b=%0d ddf=%0d zden=%0b, got rdf_a=%0d rdf_b=%0d ddf=%0d zden=%0b",
				$time, what, want.rdf_a, want.rdf_b, want.ddf, want.zero_den,
				got.rdf_a, got.rdf_b, got.ddf, got.zero_den);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pair_result_t got;
		pair_result_t want;
		if (!arst_n) begin
			held_a = '0;
			held_b = '0;
			held_valid = 1'b0;
			scale_ddf = 1'b0;
			expected_q.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				scale_ddf = cfg_wdata;
			end
			if (result.valid && result.ready) begin
				got = {result.rdf_a, result.rdf_b, result.ddf, result.zero_denominator};
				if (expected_q.size() == 0) begin
					report("result item with none expected", '0, got);
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						report("result item mismatch", want, got);
					end
				end
			end
			if (window.valid && window.ready) begin
				if (held_valid && !window.first_window) begin
					expected_q.push_back(predict_pair(window.mean_a, window.mean_b));
				end
				held_a = window.mean_a;
				held_b = window.mean_b;
				held_valid = 1'b1;
			end
			outstanding = expected_q.size();
		end
	end

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import wpdd_pkg::*;

	localparam int STALL_LIMIT  = 4000;
	localparam int IDLE_PAUSE   = 100;
	localparam int DRAIN_CYCLES = 200;
	localparam int PHASE_ITEMS  = 195;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	logic steady;
	int   mismatches;
	int   outstanding;
	int   quiet_cycles = 0;

	logic signed [FIELD_W-1:0] last_a;
	logic signed [FIELD_W-1:0] last_b;

	wpdd_window_if window();
	wpdd_result_if result();

	window_pair_double_difference i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.window    (window),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	wpdd_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.window      (window),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 20);
		end
		return $urandom_range(40, 150);
	endfunction

	function automatic logic signed [FIELD_W-1:0] pick_mean(
		input logic signed [FIELD_W-1:0] held);
		logic signed [FIELD_W-1:0] near;
		near = $signed(FIELD_W'($urandom_range(0, 4000))) - 2000;
		case ($urandom_range(0, 9))
			0, 1, 2: return $urandom;
			3, 4: return near;
			5: return -held;
			6: return -held + near;
			7: return held + near;
			8: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7FFF_FFFF;
					1: return 32'sh8000_0000;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			default: return held >>> $urandom_range(0, 31);
		endcase
	endfunction

	task automatic send_window(input logic signed [FIELD_W-1:0] a,
		input logic signed [FIELD_W-1:0] b, input logic first);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			window.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		window.valid <= 1'b1;
		window.mean_a <= a;
		window.mean_b <= b;
		window.first_window <= first;
		@(posedge clk);
		while (!window.ready) @(posedge clk);
		last_a = a;
		last_b = b;
	endtask

	task automatic settle();
		window.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (IDLE_PAUSE) @(posedge clk);
	endtask

	task automatic write_normalize(input logic value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			int gap;
			result.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			gap = gap_len();
			if (gap > 0) begin
				result.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (window.valid && window.ready) || (result.valid && result.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		logic [1:0] scale_plan [4];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		steady = 1'b0;
		window.valid = 1'b0;
		window.mean_a = '0;
		window.mean_b = '0;
		window.first_window = 1'b0;
		last_a = '0;
		last_b = '0;
		scale_plan = '{2'd0, 2'd1, 2'd0, 2'd1};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_normalize(1'b0);

		// A window with no run started is only stored.
		send_window(32'sd327680, 32'sd196608, 1'b0);
		send_window(32'sd458752, 32'sd65536, 1'b0);
		send_window(32'sd0, 32'sd0, 1'b1);
		send_window(32'sd0, 32'sd0, 1'b0);
		send_window(32'sd100000, -32'sd99999, 1'b0);
		send_window(-32'sd99999, 32'sd100000, 1'b0);
		send_window(32'sd100000, -32'sd99999, 1'b0);
		send_window(-32'sd100000, 32'sd5, 1'b0);
		send_window(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
		send_window(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
		send_window(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
		send_window(-32'sd1, 32'sd1, 1'b0);
		send_window(32'sd1, -32'sd1, 1'b0);
		send_window(32'sd3, 32'sd7, 1'b0);
		send_window(32'sh8000_0000, 32'sh8000_0000, 1'b0);
		send_window(32'sh5555_AAAA, 32'shAAAA_5555, 1'b0);
		settle();

		write_normalize(1'b1);
		send_window(-32'sd99999, 32'sd100000, 1'b1);
		send_window(32'sd100000, -32'sd99999, 1'b0);
		send_window(32'sd150000, -32'sd50000, 1'b0);
		send_window(-32'sd1, -32'sd1, 1'b0);
		send_window(32'sd1, 32'sd1, 1'b0);
		send_window(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
		settle();

		for (int phase = 0; phase < 4; phase++) begin
			write_normalize(scale_plan[phase][0]);
			steady = (phase == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_window(pick_mean(last_a), pick_mean(last_b),
					$urandom_range(0, 9) == 0);
			end
			settle();
		end
		steady = 1'b0;

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
